@@ hdl/sac_plru_pkg.sv @@
// ----------------------------------------------------------------------------
// sac_plru_pkg
// Shared types and constants of the set-associative tag store with PLRU.
// ----------------------------------------------------------------------------
package sac_plru_pkg;

	localparam int CMD_W         = 2;
	localparam int ADDR_W        = 32;
	localparam int OFFSET_W      = 4;
	localparam int DEF_SET_COUNT = 64;
	localparam int DEF_WAY_COUNT = 4;
	localparam int DEF_WAY_W     = $clog2(DEF_WAY_COUNT);
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 2;

	localparam logic [OFFSET_W-1:0]   OFFSET_RESET    = 4'd6;
	localparam logic [APB_ADDR_W-1:0] REG_LINE_OFFSET = 2'd0;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_FILL  = 2'd2
	} cmd_t;

endpackage

@@ hdl/sac_plru_if.sv @@
// ----------------------------------------------------------------------------
// sac_plru_if
// Request and response channels of the tag store, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sac_plru_req_if import sac_plru_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [ADDR_W-1:0] addr;

	modport source (output valid, output cmd, output addr, input ready);
	modport sink (input valid, input cmd, input addr, output ready);
endinterface

interface sac_plru_rsp_if import sac_plru_pkg::*; #(
	parameter int WAY_W = DEF_WAY_W
) ();
	logic             valid;
	logic             ready;
	logic             hit;
	logic [WAY_W-1:0] way;

	modport source (output valid, output hit, output way, input ready);
	modport sink (input valid, input hit, input way, output ready);
endinterface

@@ hdl/set_assoc_cache_tags_plru_unit.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_tags_plru_unit
// Tag, valid and dirty store of a set-associative cache, tree PLRU per set.
//
// Usage:
//   req carries a command (read, write or fill) and a byte address. rsp
//   returns one result per request: hit flag and way (hit way on an access
//   hit, victim way on a fill, zero otherwise).
//   The APB port holds line_offset_bits at address 0; write it only while
//   no request is outstanding.
// Timing:
//   Each request reads its set from the tag and state memories when accepted,
//   is resolved in the lookup stage and registered when that stage fires. One
//   request is accepted every cycle while rsp.ready is high and no clearing
//   pass runs; a write back to a set read by the next request is forwarded.
// Reset:
//   After arst_n is released a clearing pass zeroes the valid, dirty and
//   PLRU state one set per cycle, across all SET_COUNT sets, with req.ready low.
// Stall:
//   While rsp.ready is low a full result register holds and the lookup stage
//   holds behind it; req.ready drops once both are full, so no request is lost.
// ----------------------------------------------------------------------------
module set_assoc_cache_tags_plru_unit import sac_plru_pkg::*; #(
	parameter int SET_COUNT = DEF_SET_COUNT,
	parameter int WAY_COUNT = DEF_WAY_COUNT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sac_plru_req_if.sink          req,
	sac_plru_rsp_if.source        rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int IDX_BITS = $clog2(SET_COUNT + 1) - 1;
	localparam int SET_W    = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int TAG_W    = ADDR_W - IDX_BITS;
	localparam int WAY_W    = $clog2(WAY_COUNT);
	localparam int SPAN     = 1 << WAY_W;
	localparam int TREE_W   = SPAN - 1;
	localparam int TI_W     = (TREE_W > 1) ? $clog2(TREE_W) : 1;
	localparam int META_W   = 2 * WAY_COUNT + TREE_W;
	localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);

	typedef logic [WAY_COUNT-1:0][TAG_W-1:0] tag_row_t;
	typedef logic [TREE_W-1:0]               tree_t;
	typedef logic [WAY_W-1:0]                way_t;

	function automatic way_t plru_victim(input tree_t tree);
		int node;
		int lo;
		int size;
		int half;
		node = 1;
		lo   = 0;
		size = SPAN;
		for (int l = 0; l < WAY_W; l++) begin
			half = size >> 1;
			if (tree[TI_W'(node - 1)] && (lo + half < WAY_COUNT)) begin
				lo   = lo + half;
				node = 2 * node + 1;
			end else begin
				node = 2 * node;
			end
			size = half;
		end
		return WAY_W'(lo);
	endfunction

	function automatic tree_t plru_touch(input tree_t tree, input way_t way);
		tree_t t;
		int    node;
		int    lo;
		int    size;
		int    half;
		t    = tree;
		node = 1;
		lo   = 0;
		size = SPAN;
		for (int l = 0; l < WAY_W; l++) begin
			half = size >> 1;
			if (int'(way) < lo + half) begin
				t[TI_W'(node - 1)] = 1'b1;
				node = 2 * node;
			end else begin
				t[TI_W'(node - 1)] = 1'b0;
				lo   = lo + half;
				node = 2 * node + 1;
			end
			size = half;
		end
		return t;
	endfunction

	// configuration
	logic [OFFSET_W-1:0] off_q;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_LINE_OFFSET) ? APB_DATA_W'(off_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= OFFSET_RESET;
		end else if (psel && penable && pwrite && (paddr == REG_LINE_OFFSET)) begin
			off_q <= pwdata[OFFSET_W-1:0];
		end
	end

	// memories
	tag_row_t          tag_mem_q  [SET_COUNT];
	logic [META_W-1:0] meta_mem_q [SET_COUNT];

	// control
	logic             clr_busy_q;
	logic [SET_W-1:0] clr_idx_q;
	logic             s1_valid;
	logic             out_valid_q;
	logic             s1_fire;
	logic             req_accept;

	// lookup stage
	logic [CMD_W-1:0]  cmd_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [SET_W-1:0]  set_s1;
	tag_row_t          tag_rd_s1;
	logic [META_W-1:0] meta_rd_s1;
	logic              fwd_s1;
	tag_row_t          wr_tags_q;
	logic [META_W-1:0] wr_meta_q;

	// result
	logic hit_q;
	way_t way_q;

	// request decode
	logic [ADDR_W-1:0] addr_sh;
	logic [4:0]        tag_shamt;
	logic [SET_W-1:0]  req_set;
	logic [TAG_W-1:0]  req_tag;

	assign addr_sh   = req.addr >> off_q;
	assign req_set   = SET_W'(addr_sh & SET_MASK);
	assign tag_shamt = 5'(IDX_BITS) + {1'b0, off_q};
	assign req_tag   = TAG_W'(req.addr >> tag_shamt);

	assign s1_fire    = s1_valid && (!out_valid_q || rsp.ready);
	assign req.ready  = !clr_busy_q && (!s1_valid || s1_fire);
	assign req_accept = req.valid && req.ready;

	// resolve
	tag_row_t             eff_tags;
	logic [META_W-1:0]    eff_meta;
	logic [WAY_COUNT-1:0] eff_valid;
	logic [WAY_COUNT-1:0] eff_dirty;
	tree_t                eff_tree;
	logic                 hit_any;
	way_t                 hit_way;
	logic                 res_hit;
	way_t                 res_way;
	tag_row_t             new_tags;
	logic [WAY_COUNT-1:0] new_valid;
	logic [WAY_COUNT-1:0] new_dirty;
	tree_t                new_tree;
	logic [META_W-1:0]    new_meta;

	assign eff_tags = fwd_s1 ? wr_tags_q : tag_rd_s1;
	assign eff_meta = fwd_s1 ? wr_meta_q : meta_rd_s1;
	assign {eff_tree, eff_dirty, eff_valid} = eff_meta;

	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int w = WAY_COUNT - 1; w >= 0; w--) begin
			if (eff_valid[w] && (eff_tags[w] == tag_s1)) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		res_hit   = 1'b0;
		res_way   = '0;
		new_tags  = eff_tags;
		new_valid = eff_valid;
		new_dirty = eff_dirty;
		new_tree  = eff_tree;
		case (cmd_s1)
			CMD_READ, CMD_WRITE: begin
				if (hit_any) begin
					res_hit  = 1'b1;
					res_way  = hit_way;
					new_tree = plru_touch(eff_tree, hit_way);
					if (cmd_s1 == CMD_WRITE) begin
						new_dirty[hit_way] = 1'b1;
					end
				end
			end
			CMD_FILL: begin
				res_way            = plru_victim(eff_tree);
				new_tree           = plru_touch(eff_tree, res_way);
				new_valid[res_way] = 1'b1;
				new_dirty[res_way] = 1'b0;
				new_tags[res_way]  = tag_s1;
			end
			default: begin
			end
		endcase
	end

	assign new_meta = {new_tree, new_dirty, new_valid};

	// clearing pass and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_idx_q   <= '0;
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + SET_W'(1);
				if (clr_idx_q == SET_W'(SET_COUNT - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (req_accept) begin
				s1_valid <= 1'b1;
			end else if (s1_fire) begin
				s1_valid <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			meta_mem_q[clr_idx_q] <= '0;
		end else if (s1_fire) begin
			meta_mem_q[set_s1] <= new_meta;
		end
		if (s1_fire) begin
			tag_mem_q[set_s1] <= new_tags;
		end
		if (req_accept) begin
			tag_rd_s1  <= tag_mem_q[req_set];
			meta_rd_s1 <= meta_mem_q[req_set];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_accept) begin
			cmd_s1 <= req.cmd;
			tag_s1 <= req_tag;
			set_s1 <= req_set;
			fwd_s1 <= s1_fire && (set_s1 == req_set);
		end
		if (s1_fire) begin
			wr_tags_q <= new_tags;
			wr_meta_q <= new_meta;
			hit_q     <= res_hit;
			way_q     <= res_way;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.hit   = hit_q;
	assign rsp.way   = way_q;

	a_no_item_while_clearing: assert property (
		@(posedge clk) disable iff (!arst_n) clr_busy_q |-> !s1_valid
	) else $error("lookup stage busy during clearing pass");

	a_fill_never_hits: assert property (
		@(posedge clk) disable iff (!arst_n) (s1_fire && cmd_s1 == CMD_FILL) |=> !hit_q
	) else $error("fill reported a hit");

	a_nop_zero_result: assert property (
		@(posedge clk) disable iff (!arst_n)
		(s1_fire && cmd_s1 != CMD_READ && cmd_s1 != CMD_WRITE && cmd_s1 != CMD_FILL)
		|=> (!hit_q && way_q == '0)
	) else $error("unused command gave a non-zero result");

	a_way_in_range: assert property (
		@(posedge clk) disable iff (!arst_n) out_valid_q |-> (int'(way_q) < WAY_COUNT)
	) else $error("result way beyond the number of ways");

endmodule
